/* rtl/scba_pkg.sv */
// types, constants and helper functions shared by the size class allocator
package scba_pkg;

    localparam int PAGES_PER_CLASS = 2;
    localparam int NUM_CLASSES     = 5;
    localparam int NUM_PAGES       = NUM_CLASSES * PAGES_PER_CLASS;
    localparam int PAGE_W          = $clog2(NUM_PAGES);

    localparam int BITMAP_W        = 128;
    localparam int BLK_W           = $clog2(BITMAP_W);
    localparam int MAX_BLOCKS      = 127;
    localparam int CNT_W           = $clog2(MAX_BLOCKS * PAGES_PER_CLASS + 1);
    localparam int CLS_W           = 3;

    localparam int ADDR_W          = 16;
    localparam int SIZE_W          = 10;
    localparam int CNT_OUT_W       = 8;
    localparam int CNT_OUT_MAX     = 255;
    localparam int OFF_W           = 12;
    localparam int ADDR_PG_W       = ADDR_W - OFF_W;
    localparam int PG_CMP_W        = ((PAGE_W > ADDR_PG_W) ? PAGE_W : ADDR_PG_W) + 1;
    localparam int SHIFT_W         = 4;

    localparam int HEADER_BYTES    = 32;
    localparam int MIN_BLOCK_BYTES = 32;
    localparam int LOG_MIN_BLOCK   = 5;
    localparam int MAX_REQ_BYTES   = 512;

    typedef logic [CLS_W-1:0]    cls_t;
    typedef logic [BLK_W-1:0]    blk_t;
    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [BITMAP_W-1:0] bitmap_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_NO_FREE,
        STATUS_TOO_BIG,
        STATUS_BAD_FREE
    } status_t;

    typedef enum logic {
        CMD_ALLOC,
        CMD_FREE
    } cmd_t;

    typedef struct packed {
        logic has_free;
        blk_t first_free;
    } scan_t;

    typedef struct packed {
        logic  valid;
        page_t page;
        blk_t  blk;
    } free_loc_t;

    function automatic cls_t class_of(input logic [SIZE_W-1:0] size);
        cls_t c;
        if (size > SIZE_W'(256))
            c = CLS_W'(4);
        else if (size > SIZE_W'(128))
            c = CLS_W'(3);
        else if (size > SIZE_W'(64))
            c = CLS_W'(2);
        else if (size > SIZE_W'(32))
            c = CLS_W'(1);
        else
            c = CLS_W'(0);
        return c;
    endfunction

    function automatic blk_t blocks_per_page(input cls_t c);
        blk_t n;
        case (c)
            CLS_W'(0): n = BLK_W'(127);
            CLS_W'(1): n = BLK_W'(63);
            CLS_W'(2): n = BLK_W'(31);
            CLS_W'(3): n = BLK_W'(15);
            default:   n = BLK_W'(7);
        endcase
        return n;
    endfunction

    function automatic bitmap_t block_limit_mask(input cls_t c);
        bitmap_t m;
        blk_t    n;
        n = blocks_per_page(c);
        for (int i = 0; i < BITMAP_W; i++)
            m[i] = (BLK_W'(i) < n);
        return m;
    endfunction

    function automatic cnt_t count_reset(input cls_t c);
        return CNT_W'(int'(blocks_per_page(c)) * PAGES_PER_CLASS);
    endfunction

endpackage

/* rtl/scba_req_if.sv */
// request channel: command, size and address to free
interface scba_req_if
    import scba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                cmd;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   block_address;

    modport source (output valid, cmd, request_size, block_address, input ready);
    modport sink   (input valid, cmd, request_size, block_address, output ready);
endinterface

/* rtl/scba_rsp_if.sv */
// response channel: status, granted address and class summary
interface scba_rsp_if
    import scba_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic [ADDR_W-1:0]     granted_address;
    logic [SIZE_W-1:0]     class_block_size;
    logic [CNT_OUT_W-1:0]  class_free_blocks;

    modport source (output valid, status, granted_address, class_block_size,
                    class_free_blocks, input ready);
    modport sink   (input valid, status, granted_address, class_block_size,
                    class_free_blocks, output ready);
endinterface

/* rtl/scba_page_scan.sv */
// lowest free block finder for one page bitmap
module scba_page_scan
    import scba_pkg::*;
(
    input  cls_t    cls,
    input  bitmap_t bitmap,
    output scan_t   scan
);

    bitmap_t free_vec;

    always_comb
    begin
        free_vec        = ~bitmap & block_limit_mask(cls);
        scan.has_free   = |free_vec;
        scan.first_free = '0;
        for (int i = BITMAP_W - 1; i >= 0; i--)
        begin
            if (free_vec[i])
                scan.first_free = BLK_W'(i);
        end
    end

endmodule

/* rtl/scba_free_decode.sv */
// free address check: class page range, header, block alignment and limit
module scba_free_decode
    import scba_pkg::*;
(
    input  cls_t              cls,
    input  logic [ADDR_W-1:0] addr,
    output free_loc_t         loc
);

    logic [PG_CMP_W-1:0] addr_page;
    logic [PG_CMP_W-1:0] base;
    logic [OFF_W-1:0]    off;
    logic [OFF_W-1:0]    rel;
    logic [OFF_W-1:0]    align_mask;
    logic [OFF_W-1:0]    idx;
    logic [SHIFT_W-1:0]  shift;
    logic                in_class;

    always_comb
    begin
        addr_page  = PG_CMP_W'(addr[ADDR_W-1:OFF_W]);
        base       = PG_CMP_W'(cls) * PG_CMP_W'(PAGES_PER_CLASS);
        off        = addr[OFF_W-1:0];
        rel        = off - OFF_W'(HEADER_BYTES);
        shift      = SHIFT_W'(LOG_MIN_BLOCK) + SHIFT_W'(cls);
        align_mask = (OFF_W'(1) << shift) - OFF_W'(1);
        idx        = rel >> shift;
        in_class   = (addr_page >= base) && (addr_page < base + PG_CMP_W'(PAGES_PER_CLASS));

        loc.valid  = in_class
                     && (off >= OFF_W'(HEADER_BYTES))
                     && ((rel & align_mask) == '0)
                     && (idx < OFF_W'(blocks_per_page(cls)));
        loc.page   = PAGE_W'(addr_page);
        loc.blk    = BLK_W'(idx);
    end

endmodule

/* rtl/size_class_bitmap_allocator_core.sv */
// Size class bitmap allocator top level. Requests are captured in an input register,
// resolved in one pass through per-page priority encoders and the free address check,
// and the answer lands in a result register; one request is taken every cycle while
// responses drain. A stalled response holds both stages, so at most two requests are in
// flight. The bitmaps are flip-flops cleared by reset and the free counters are loaded
// with each class's full block count, so the block is usable right after reset with no
// clearing pass.
module size_class_bitmap_allocator_core
    import scba_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    scba_req_if.sink       req,
    scba_rsp_if.source     rsp
);

    // input stage
    logic                  in_valid_reg, in_valid_next;
    logic                  cmd_reg, cmd_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [ADDR_W-1:0]     granted_reg, granted_next;
    logic [SIZE_W-1:0]     bsize_reg, bsize_next;
    logic [CNT_OUT_W-1:0]  free_out_reg, free_out_next;

    // allocator state
    bitmap_t               bitmap_reg [NUM_PAGES];
    bitmap_t               bitmap_next [NUM_PAGES];
    cnt_t                  count_reg [NUM_CLASSES];
    cnt_t                  count_next [NUM_CLASSES];

    logic                  advance;
    logic                  req_fire;
    logic                  too_big;
    cls_t                  cls;
    scan_t                 scan [NUM_PAGES];
    free_loc_t             free_loc;
    logic                  found;
    page_t                 sel_page;
    blk_t                  sel_blk;
    logic                  freed_bit;
    cnt_t                  cur_cnt;
    cnt_t                  new_cnt;
    logic                  do_alloc;
    logic                  do_free;
    logic [OFF_W-1:0]      grant_off;
    status_t               status_c;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    assign too_big   = (size_reg > SIZE_W'(MAX_REQ_BYTES));
    assign cls       = class_of(size_reg);

    for (genvar k = 0; k < NUM_PAGES; k++)
    begin : g_scan
        scba_page_scan u_scan (
            .cls    (CLS_W'(k / PAGES_PER_CLASS)),
            .bitmap (bitmap_reg[k]),
            .scan   (scan[k])
        );
    end

    scba_free_decode u_free_decode (
        .cls  (cls),
        .addr (addr_reg),
        .loc  (free_loc)
    );

    // highest page of the class with a free block wins
    always_comb
    begin
        found     = 1'b0;
        sel_page  = '0;
        sel_blk   = '0;
        freed_bit = 1'b0;
        for (int k = 0; k < NUM_PAGES; k++)
        begin
            if ((CLS_W'(k / PAGES_PER_CLASS) == cls) && scan[k].has_free)
            begin
                found    = 1'b1;
                sel_page = PAGE_W'(k);
                sel_blk  = scan[k].first_free;
            end
            if (PAGE_W'(k) == free_loc.page)
                freed_bit = bitmap_reg[k][free_loc.blk];
        end
    end

    always_comb
    begin
        cur_cnt  = count_reg[cls];
        do_alloc = !too_big && (cmd_reg == CMD_ALLOC) && (cur_cnt != '0) && found;
        do_free  = !too_big && (cmd_reg == CMD_FREE) && free_loc.valid && freed_bit;
        new_cnt  = cur_cnt - CNT_W'(do_alloc) + CNT_W'(do_free);

        if (too_big)
            status_c = STATUS_TOO_BIG;
        else if (cmd_reg == CMD_ALLOC)
            status_c = do_alloc ? STATUS_OK : STATUS_NO_FREE;
        else
            status_c = do_free ? STATUS_OK : STATUS_BAD_FREE;

        grant_off = OFF_W'(HEADER_BYTES)
                    + (OFF_W'(sel_blk) << (SHIFT_W'(LOG_MIN_BLOCK) + SHIFT_W'(cls)));
    end

    // next state
    always_comb
    begin
        in_valid_next = req_fire || (in_valid_reg && !advance);
        cmd_next      = req_fire ? req.cmd : cmd_reg;
        size_next     = req_fire ? req.request_size : size_reg;
        addr_next     = req_fire ? req.block_address : addr_reg;

        out_valid_next = advance || (out_valid_reg && !rsp.ready);
        status_next    = status_reg;
        granted_next   = granted_reg;
        bsize_next     = bsize_reg;
        free_out_next  = free_out_reg;

        for (int k = 0; k < NUM_PAGES; k++)
        begin
            bitmap_next[k] = bitmap_reg[k];
            if (advance && do_alloc && (sel_page == PAGE_W'(k)))
                bitmap_next[k][sel_blk] = 1'b1;
            if (advance && do_free && (free_loc.page == PAGE_W'(k)))
                bitmap_next[k][free_loc.blk] = 1'b0;
        end

        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            count_next[c] = count_reg[c];
            if (advance && (cls == CLS_W'(c)))
                count_next[c] = new_cnt;
        end

        if (advance)
        begin
            status_next = status_c;
            if (too_big)
            begin
                granted_next  = '0;
                bsize_next    = '0;
                free_out_next = '0;
            end
            else
            begin
                granted_next  = do_alloc ? {ADDR_PG_W'(sel_page), grant_off} : '0;
                bsize_next    = SIZE_W'(MIN_BLOCK_BYTES) << cls;
                free_out_next = (int'(new_cnt) > CNT_OUT_MAX) ? CNT_OUT_W'(CNT_OUT_MAX)
                                                              : CNT_OUT_W'(new_cnt);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_PAGES; k++)
                bitmap_reg[k] <= '0;
            for (int c = 0; c < NUM_CLASSES; c++)
                count_reg[c] <= count_reset(CLS_W'(c));
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < NUM_PAGES; k++)
                bitmap_reg[k] <= bitmap_next[k];
            for (int c = 0; c < NUM_CLASSES; c++)
                count_reg[c] <= count_next[c];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        size_reg     <= size_next;
        addr_reg     <= addr_next;
        status_reg   <= status_next;
        granted_reg  <= granted_next;
        bsize_reg    <= bsize_next;
        free_out_reg <= free_out_next;
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.status            = status_reg;
    assign rsp.granted_address   = granted_reg;
    assign rsp.class_block_size  = bsize_reg;
    assign rsp.class_free_blocks = free_out_reg;

endmodule

/* verif/scba_alloc_checker.sv */
// checker for the size class allocator: predicts every answer and compares response beats
`timescale 1ns / 1ps
module scba_alloc_checker
    import scba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    scba_req_if  req,
    scba_rsp_if  rsp,
    output int   mismatches,
    output int   answers_due,
    output int   ok_cnt,
    output int   no_free_cnt,
    output int   too_big_cnt,
    output int   bad_free_cnt
);

    localparam int PAGE_BYTES = 1 << OFF_W;

    typedef struct {
        status_t               status;
        logic [ADDR_W-1:0]     granted;
        logic [SIZE_W-1:0]     blk_size;
        logic [CNT_OUT_W-1:0]  free_left;
    } answer_t;

    logic [BITMAP_W-1:0] used_map [NUM_PAGES];
    int                  free_blocks [NUM_CLASSES];
    answer_t             pending_answers [$];
    int                  err_cnt;
    int                  stat_cnt [4];

    function automatic int blocks_in_page(input int cls);
        return (PAGE_BYTES - HEADER_BYTES) / (MIN_BLOCK_BYTES << cls);
    endfunction

    function automatic answer_t serve_request(input cmd_t op, input logic [SIZE_W-1:0] size,
                                              input logic [ADDR_W-1:0] addr);
        answer_t a;
        int      cls;
        int      bsize;
        int      nblk;
        int      page;
        int      base;
        int      rel;
        int      off;
        int      idx;
        bit      found;
        a.status    = STATUS_OK;
        a.granted   = '0;
        a.blk_size  = '0;
        a.free_left = '0;
        if (size > MAX_REQ_BYTES)
        begin
            a.status = STATUS_TOO_BIG;
            return a;
        end
        cls   = (size > 256) ? 4 : (size > 128) ? 3 : (size > 64) ? 2 : (size > 32) ? 1 : 0;
        bsize = MIN_BLOCK_BYTES << cls;
        nblk  = blocks_in_page(cls);
        found = 1'b0;
        if (op == CMD_ALLOC)
        begin
            if (free_blocks[cls] != 0)
            begin
                for (int j = PAGES_PER_CLASS - 1; j >= 0 && !found; j--)
                begin
                    page = cls * PAGES_PER_CLASS + j;
                    for (int i = 0; i < nblk && !found; i++)
                    begin
                        if (!used_map[page][i])
                        begin
                            used_map[page][i] = 1'b1;
                            a.granted = ADDR_W'(page * PAGE_BYTES + HEADER_BYTES + i * bsize);
                            found = 1'b1;
                        end
                    end
                end
            end
            if (found)
                free_blocks[cls]--;
            else
                a.status = STATUS_NO_FREE;
        end
        else
        begin
            base     = cls * PAGES_PER_CLASS * PAGE_BYTES;
            a.status = STATUS_BAD_FREE;
            if (int'(addr) >= base && int'(addr) < base + PAGES_PER_CLASS * PAGE_BYTES)
            begin
                rel  = int'(addr) - base;
                page = cls * PAGES_PER_CLASS + rel / PAGE_BYTES;
                off  = rel % PAGE_BYTES;
                if (off >= HEADER_BYTES && ((off - HEADER_BYTES) % bsize) == 0)
                begin
                    idx = (off - HEADER_BYTES) / bsize;
                    if (idx < nblk && used_map[page][idx])
                    begin
                        used_map[page][idx] = 1'b0;
                        free_blocks[cls]++;
                        a.status = STATUS_OK;
                    end
                end
            end
        end
        a.blk_size  = SIZE_W'(bsize);
        a.free_left = (free_blocks[cls] > CNT_OUT_MAX) ? CNT_OUT_W'(CNT_OUT_MAX)
                                                       : CNT_OUT_W'(free_blocks[cls]);
        return a;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PAGES; p++)
                used_map[p] = '0;
            for (int c = 0; c < NUM_CLASSES; c++)
                free_blocks[c] = blocks_in_page(c) * PAGES_PER_CLASS;
            pending_answers.delete();
            err_cnt  = 0;
            stat_cnt = '{default: 0};
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (pending_answers.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: response with none expected, status %0d address %0d",
                             $time, rsp.status, rsp.granted_address);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("granted_address", want.granted, rsp.granted_address);
                    check_field("class_block_size", want.blk_size, rsp.class_block_size);
                    check_field("class_free_blocks", want.free_left, rsp.class_free_blocks);
                    stat_cnt[want.status]++;
                end
            end
            if (req.valid && req.ready)
                pending_answers.push_back(serve_request(cmd_t'(req.cmd), req.request_size,
                                                        req.block_address));
        end
        mismatches   <= err_cnt;
        answers_due  <= pending_answers.size();
        ok_cnt       <= stat_cnt[STATUS_OK];
        no_free_cnt  <= stat_cnt[STATUS_NO_FREE];
        too_big_cnt  <= stat_cnt[STATUS_TOO_BIG];
        bad_free_cnt <= stat_cnt[STATUS_BAD_FREE];
    end

endmodule

/* verif/tb_size_class_bitmap_allocator_core.sv */
// testbench top for the size class allocator: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module tb_size_class_bitmap_allocator_core
    import scba_pkg::*;
();

    localparam int PAGE_BYTES   = 1 << OFF_W;
    localparam int ADDR_TOP     = NUM_PAGES * PAGE_BYTES - 1;
    localparam int RANDOM_ITEMS = 400;
    localparam int LONG_HOLD    = 80;
    localparam int IDLE_LIMIT   = 3000;

    logic clk;
    logic rst_n;

    scba_req_if req_ch ();
    scba_rsp_if rsp_ch ();

    int mismatches;
    int answers_due;
    int ok_cnt;
    int no_free_cnt;
    int too_big_cnt;
    int bad_free_cnt;

    logic [ADDR_W-1:0] live_blocks [$];
    bit                steady;
    bit                long_hold_req;
    int                beats_sent;
    int                idle_cycles;

    size_class_bitmap_allocator_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    scba_alloc_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .mismatches   (mismatches),
        .answers_due  (answers_due),
        .ok_cnt       (ok_cnt),
        .no_free_cnt  (no_free_cnt),
        .too_big_cnt  (too_big_cnt),
        .bad_free_cnt (bad_free_cnt)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic int size_in_class(input int cls);
        if (cls == 0)
            return $urandom_range(0, MIN_BLOCK_BYTES);
        return $urandom_range((MIN_BLOCK_BYTES << (cls - 1)) + 1, MIN_BLOCK_BYTES << cls);
    endfunction

    function automatic int owner_class(input logic [ADDR_W-1:0] a);
        return (int'(a) / PAGE_BYTES) / PAGES_PER_CLASS;
    endfunction

    task automatic send_beat(input cmd_t op, input int size, input int addr);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= op;
        req_ch.request_size  <= SIZE_W'(size);
        req_ch.block_address <= ADDR_W'(addr);
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_alloc(input int cls);
        send_beat(CMD_ALLOC, size_in_class(cls), $urandom_range(0, ADDR_TOP));
    endtask

    task automatic free_live_block();
        int                k;
        logic [ADDR_W-1:0] a;
        k = $urandom_range(0, live_blocks.size() - 1);
        a = live_blocks[k];
        live_blocks.delete(k);
        send_beat(CMD_FREE, size_in_class(owner_class(a)), a);
    endtask

    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (answers_due != 0)
            @(posedge clk);
    endtask

    // addresses handed out by the block become candidates for later frees
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == STATUS_OK
            && rsp_ch.granted_address != '0)
            live_blocks.push_back(rsp_ch.granted_address);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int rcv_cycle;
        int stall_left;
        rsp_ch.ready = 1'b0;
        rcv_cycle    = 0;
        stall_left   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            rcv_cycle++;
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                stall_left = LONG_HOLD - 1;
            end
            else if ((rcv_cycle % 500) < 60 || $urandom_range(0, 99) < 70)
                rsp_ch.ready <= 1'b1;
            else
            begin
                rsp_ch.ready <= 1'b0;
                stall_left = pick_gap();
            end
        end
    end

    initial
    begin
        int                r;
        int                cls;
        int                random_sent;
        bit                held;
        bit                drained;
        logic [ADDR_W-1:0] victim;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_ALLOC;
        req_ch.request_size  = '0;
        req_ch.block_address = '0;
        steady               = 1'b0;
        long_hold_req        = 1'b0;
        beats_sent           = 0;
        idle_cycles          = 0;
        held                 = 1'b0;
        drained              = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one allocation at each class boundary, zero size included
        send_beat(CMD_ALLOC, 0, 0);
        send_beat(CMD_ALLOC, 32, ADDR_TOP);
        send_beat(CMD_ALLOC, 33, 0);
        send_beat(CMD_ALLOC, 64, 0);
        send_beat(CMD_ALLOC, 65, 0);
        send_beat(CMD_ALLOC, 128, 0);
        send_beat(CMD_ALLOC, 129, 0);
        send_beat(CMD_ALLOC, 256, 0);
        send_beat(CMD_ALLOC, 257, 0);
        send_beat(CMD_ALLOC, 512, 0);
        // oversize on both commands
        send_beat(CMD_ALLOC, 513, 0);
        send_beat(CMD_FREE, 1023, ADDR_TOP);
        // rejected frees: header, off boundary, other class, past last block,
        // never allocated, last byte of the last page
        send_beat(CMD_FREE, 0, 0);
        send_beat(CMD_FREE, 1, PAGE_BYTES + HEADER_BYTES + 1);
        send_beat(CMD_FREE, 40, HEADER_BYTES);
        send_beat(CMD_FREE, 300,
                  4 * PAGES_PER_CLASS * PAGE_BYTES + HEADER_BYTES + 7 * MAX_REQ_BYTES);
        send_beat(CMD_FREE, 512, 4 * PAGES_PER_CLASS * PAGE_BYTES + HEADER_BYTES);
        send_beat(CMD_FREE, 0, ADDR_TOP);
        wait_all_answered();

        // good free followed by a double free of the same block
        victim = live_blocks.pop_front();
        send_beat(CMD_FREE, size_in_class(owner_class(victim)), victim);
        send_beat(CMD_FREE, size_in_class(owner_class(victim)), victim);
        free_live_block();
        free_live_block();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            steady = (random_sent % 120) < 25;
            if (!held && random_sent >= 125)
            begin
                long_hold_req = 1'b1;
                held          = 1'b1;
            end
            if (!drained && random_sent >= 260)
            begin
                wait_all_answered();
                drained = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                // run a small class dry and past its end
                cls = $urandom_range(3, 4);
                repeat ((PAGE_BYTES - HEADER_BYTES) / (MIN_BLOCK_BYTES << cls)
                        * PAGES_PER_CLASS + 2)
                begin
                    send_alloc(cls);
                    random_sent++;
                end
            end
            else if (r < 47)
            begin
                r = $urandom_range(0, 99);
                cls = (r < 15) ? 0 : (r < 30) ? 1 : (r < 50) ? 2 : (r < 75) ? 3 : 4;
                send_alloc(cls);
                random_sent++;
            end
            else if (r < 82 && live_blocks.size() > 0)
            begin
                free_live_block();
                random_sent++;
            end
            else
            begin
                r = $urandom_range(0, 2);
                if (r == 0 || live_blocks.size() == 0)
                    send_beat(cmd_t'($urandom_range(0, 1)), $urandom_range(0, 1023),
                              $urandom_range(0, ADDR_TOP));
                else
                begin
                    victim = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
                    cls = owner_class(victim);
                    if (r == 1)
                        send_beat(CMD_FREE, size_in_class(cls),
                                  int'(victim) + $urandom_range(1, 40));
                    else
                        send_beat(CMD_FREE, size_in_class((cls + $urandom_range(1, 4)) % 5),
                                  victim);
                end
                random_sent++;
            end
        end

        wait_all_answered();
        repeat (4) @(posedge clk);

        $display("%0d request beats: %0d accepted, %0d class exhausted, %0d oversize, %0d %s",
                 beats_sent, ok_cnt, no_free_cnt, too_big_cnt, bad_free_cnt, "bad frees");
        $display("covered class boundaries, exhausted classes, a long response hold-off and drains");
        if (mismatches == 0 && answers_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
